// ===== hdl/rbws_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring buffer window sum package
// Shared sizes, item kind codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rbws_pkg;

   localparam int unsigned DEPTH        = 64;
   localparam int unsigned ADDR_WIDTH   = $clog2(DEPTH);
   localparam int unsigned COUNT_WIDTH  = $clog2(DEPTH + 1);
   localparam int unsigned SAMPLE_WIDTH = 32;
   localparam int unsigned LEN_WIDTH    = 7;
   localparam int unsigned KIND_WIDTH   = 2;
   localparam int unsigned CMP_WIDTH    =
      (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
   localparam int unsigned REQ_DATA_WIDTH =
      ((SAMPLE_WIDTH + LEN_WIDTH + 7) / 8) * 8;

   localparam logic [KIND_WIDTH-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic add_sample;
      logic clear_count;
      logic start_query;
      logic issue_read;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic remaining_zero;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/ring_buffer_window_sum.sv =====
// ----------------------------------------------------------------------------
// Ring buffer window sum
// Keeps the newest signed 32-bit samples in a ring and returns the wrapping
// total of the newest ones on request.
//
// The request channel carries one item per handshake: tuser holds the kind
// (add, clear or query), tdata holds the sample and the window length. An add
// stores the sample and a clear empties the ring; neither of the two gives
// a result. A query returns one item on the response channel with the total
// of the newest min(window_length, fill) samples.
// A query of n samples reads the sample memory one entry per cycle through
// its single read port; the block takes no new item until the total of that
// query has been loaded into the result register.
// The result register lets the next item be accepted while a total waits;
// a further query holds its total until the receiver takes the pending one.
// Reset empties the ring and drops any pending result; the block is ready
// in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_window_sum (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // Fields from bit 0: sample[31:0], window_length[38:32], zero fill.
   input  wire logic [rbws_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // Fields from bit 0: kind[1:0].
   input  wire logic [rbws_pkg::KIND_WIDTH-1:0]         req_tuser,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // Fields from bit 0: total[31:0].
   output logic [rbws_pkg::SAMPLE_WIDTH-1:0]            rsp_tdata
);

   rbws_pkg::cmd_type    cmd;
   rbws_pkg::status_type status;

   logic signed [rbws_pkg::SAMPLE_WIDTH-1:0] sample;
   logic [rbws_pkg::LEN_WIDTH-1:0]           window_length;
   logic signed [rbws_pkg::SAMPLE_WIDTH-1:0] total;

   assign sample        = req_tdata[rbws_pkg::SAMPLE_WIDTH-1:0];
   assign window_length =
      req_tdata[rbws_pkg::SAMPLE_WIDTH +: rbws_pkg::LEN_WIDTH];
   assign rsp_tdata     = total;

   rbws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   rbws_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .sample        (sample),
      .window_length (window_length),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .total         (total)
   );

endmodule

`default_nettype wire

// ===== hdl/rbws_datapath.sv =====
// ----------------------------------------------------------------------------
// Ring buffer window sum datapath
// Sample memory, write position, fill count, read walker, accumulator and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbws_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rbws_pkg::cmd_type                     cmd,
   output rbws_pkg::status_type                       status,
   input  wire logic signed [rbws_pkg::SAMPLE_WIDTH-1:0] sample,
   input  wire logic [rbws_pkg::LEN_WIDTH-1:0]        window_length,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic signed [rbws_pkg::SAMPLE_WIDTH-1:0]   total
);

   logic [rbws_pkg::SAMPLE_WIDTH-1:0] mem [rbws_pkg::DEPTH];

   logic [rbws_pkg::ADDR_WIDTH-1:0]   wr_pos_ff,    wr_pos_in;
   logic [rbws_pkg::COUNT_WIDTH-1:0]  fill_ff,      fill_in;
   logic [rbws_pkg::ADDR_WIDTH-1:0]   rd_pos_ff,    rd_pos_in;
   logic [rbws_pkg::COUNT_WIDTH-1:0]  remaining_ff, remaining_in;
   logic [rbws_pkg::SAMPLE_WIDTH-1:0] rd_data_ff;
   logic                              rd_valid_ff,  rd_valid_in;
   logic [rbws_pkg::SAMPLE_WIDTH-1:0] acc_ff,       acc_in;
   logic [rbws_pkg::SAMPLE_WIDTH-1:0] total_ff;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [rbws_pkg::CMP_WIDTH-1:0]    len_ext;
   logic [rbws_pkg::CMP_WIDTH-1:0]    fill_ext;
   logic [rbws_pkg::ADDR_WIDTH-1:0]   wr_next;

   localparam logic [rbws_pkg::ADDR_WIDTH-1:0] LastAddr =
      rbws_pkg::ADDR_WIDTH'(rbws_pkg::DEPTH - 1);
   localparam logic [rbws_pkg::COUNT_WIDTH-1:0] FullCount =
      rbws_pkg::COUNT_WIDTH'(rbws_pkg::DEPTH);

   always_comb begin
      len_ext  = rbws_pkg::CMP_WIDTH'(window_length);
      fill_ext = rbws_pkg::CMP_WIDTH'(fill_ff);
      wr_next  = (wr_pos_ff == LastAddr) ? '0 : wr_pos_ff + 1'b1;

      wr_pos_in = wr_pos_ff;
      fill_in   = fill_ff;
      if (cmd.add_sample) begin
         wr_pos_in = wr_next;
         if (fill_ff != FullCount) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.clear_count) begin
         fill_in = '0;
      end

      rd_pos_in    = rd_pos_ff;
      remaining_in = remaining_ff;
      rd_valid_in  = 1'b0;
      if (cmd.start_query) begin
         rd_pos_in    = wr_pos_ff;
         remaining_in = (len_ext < fill_ext) ?
                        rbws_pkg::COUNT_WIDTH'(len_ext) : fill_ff;
      end else if (cmd.issue_read) begin
         rd_pos_in    = (rd_pos_ff == '0) ? LastAddr : rd_pos_ff - 1'b1;
         remaining_in = remaining_ff - 1'b1;
         rd_valid_in  = 1'b1;
      end

      acc_in = acc_ff;
      if (cmd.start_query) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         acc_in = acc_ff + rd_data_ff;
      end

      rsp_valid_in = cmd.load_result | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (cmd.add_sample) begin
         mem[wr_next] <= sample;
      end
      if (cmd.issue_read) begin
         rd_data_ff <= mem[rd_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         fill_ff      <= '0;
         remaining_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pos_ff    <= wr_pos_in;
         fill_ff      <= fill_in;
         remaining_ff <= remaining_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
      acc_ff    <= acc_in;
      if (cmd.load_result) begin
         total_ff <= acc_ff;
      end
   end

   always_comb begin
      status.remaining_zero = (remaining_ff == '0);
      status.rsp_busy       = rsp_valid_ff & ~rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign total      = total_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FullCount)
      else $error("Fill count exceeds the ring depth.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !(rsp_valid_ff && !rsp_tready))
      else $error("Result register loaded while a result is still pending.");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue_read |-> remaining_ff != '0)
      else $error("Read issued past the end of the window.");

   a_query_starts_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.start_query |=> acc_ff == '0 && !rd_valid_ff)
      else $error("Accumulator not cleared at the start of a query.");

endmodule

`default_nettype wire

// ===== hdl/rbws_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring buffer window sum controller
// Accepts items, steps the datapath through a query and hands the total to
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbws_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rbws_pkg::KIND_WIDTH-1:0]   kind,
   input  wire rbws_pkg::status_type              status,
   output rbws_pkg::cmd_type                      cmd
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StSum    = 2'd1;
   localparam logic [1:0] StFinish = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   always_comb begin
      req_tready = (state_ff == StIdle);
      accept     = req_tvalid & req_tready;
      cmd        = '0;
      state_in   = state_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               case (kind)
                  rbws_pkg::KIND_ADD:   cmd.add_sample  = 1'b1;
                  rbws_pkg::KIND_CLEAR: cmd.clear_count = 1'b1;
                  rbws_pkg::KIND_QUERY: begin
                     cmd.start_query = 1'b1;
                     state_in        = StSum;
                  end
                  default: ;
               endcase
            end
         end
         StSum: begin
            if (status.remaining_zero) begin
               state_in = StFinish;
            end else begin
               cmd.issue_read = 1'b1;
            end
         end
         StFinish: begin
            if (!status.rsp_busy) begin
               cmd.load_result = 1'b1;
               state_in        = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ring buffer window sum testbench
// Drives add, clear, query and unused-kind items into the ring, tracks the
// ring contents, write position and fill count in a shadow copy, and compares
// every returned total with the typed-in or predicted one. The sender works
// in bursts, the receiver stalls on its own pattern and once holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam real         CLOCK_PERIOD   = 4.0;
   localparam int          RESET_CYCLES   = 12;
   localparam int          RANDOM_ITEMS   = 1230;
   localparam int          CYCLE_LIMIT    = 1_000_000;
   localparam int          DRAIN_CYCLES   = rbws_pkg::DEPTH + 16;
   localparam int          HOLD_START     = 1500;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          REPORT_LIMIT   = 10;
   localparam logic [rbws_pkg::KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;

   typedef logic [rbws_pkg::SAMPLE_WIDTH-1:0]   sample_type;
   typedef logic [rbws_pkg::LEN_WIDTH-1:0]      length_type;
   typedef logic [rbws_pkg::KIND_WIDTH-1:0]     kind_type;
   typedef logic [rbws_pkg::REQ_DATA_WIDTH-1:0] req_data_type;

   typedef struct packed {
      kind_type   kind;
      sample_type sample;
      length_type len;
      logic       typed_in;
      sample_type total;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 20;

   // Rows marked as typed in carry their total; the others use the prediction.
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd0,   1'b1, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'hFFFF_FFFF, 7'd64,  1'b1, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd127, 1'b1, 32'h0000_0000},
      '{rbws_pkg::KIND_ADD,   32'h7FFF_FFFF, 7'd127, 1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_ADD,   32'h0000_0001, 7'd0,   1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd2,   1'b1, 32'h8000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd1,   1'b1, 32'h0000_0001},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd127, 1'b1, 32'h8000_0000},
      '{KIND_UNUSED,          32'hFFFF_FFFF, 7'd127, 1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd2,   1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 7'd127, 1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd64,  1'b1, 32'h0000_0000},
      '{rbws_pkg::KIND_ADD,   32'h8000_0000, 7'd0,   1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_ADD,   32'hFFFF_FFFF, 7'd0,   1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd2,   1'b1, 32'h7FFF_FFFF},
      '{rbws_pkg::KIND_QUERY, 32'hFFFF_FFFF, 7'd0,   1'b1, 32'h0000_0000},
      '{rbws_pkg::KIND_ADD,   32'h0000_0000, 7'd127, 1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd3,   1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_QUERY, 32'h0000_0000, 7'd65,  1'b0, 32'h0000_0000},
      '{rbws_pkg::KIND_CLEAR, 32'h0000_0000, 7'd0,   1'b0, 32'h0000_0000}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // Fields from bit 0: sample[31:0], window_length[38:32], zero fill.
   req_data_type              req_tdata;
   // Fields from bit 0: kind[1:0].
   kind_type                  req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // Fields from bit 0: total[31:0].
   sample_type                rsp_tdata;

   sample_type  shadow_ring [rbws_pkg::DEPTH];
   int unsigned shadow_head;
   int unsigned shadow_fill;
   sample_type  expected_totals [$];
   sample_type  oldest_total;
   int          failures;
   int          burst_left;
   int          cycle_count;

   ring_buffer_window_sum dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   function automatic sample_type predict_window_total(length_type len);
      int unsigned count;
      int unsigned pos;
      int unsigned i;
      sample_type  acc;
      count = len;
      if (count > shadow_fill) count = shadow_fill;
      if (count > rbws_pkg::DEPTH) count = rbws_pkg::DEPTH;
      acc = '0;
      pos = shadow_head;
      for (i = 0; i < count; i++) begin
         acc += shadow_ring[pos];
         pos = (pos == 0) ? rbws_pkg::DEPTH - 1 : pos - 1;
      end
      return acc;
   endfunction

   task automatic log_failure(string what, sample_type want, sample_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t: %s: expected total %h, got %h", $realtime, what, want, got);
      end
   endtask

   task automatic drive_item(kind_type kind, sample_type sample, length_type len,
                             logic typed_in, sample_type typed_total);
      req_data_type word;
      word = '0;
      word[rbws_pkg::SAMPLE_WIDTH-1:0] = sample;
      word[rbws_pkg::SAMPLE_WIDTH +: rbws_pkg::LEN_WIDTH] = len;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (kind)
         rbws_pkg::KIND_ADD: begin
            shadow_head = (shadow_head == rbws_pkg::DEPTH - 1) ? 0 : shadow_head + 1;
            shadow_ring[shadow_head] = sample;
            if (shadow_fill < rbws_pkg::DEPTH) shadow_fill++;
         end
         rbws_pkg::KIND_CLEAR: begin
            shadow_fill = 0;
         end
         rbws_pkg::KIND_QUERY: begin
            expected_totals.push_back(typed_in ? typed_total : predict_window_total(len));
         end
         default: begin
         end
      endcase
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= req_data_type'({$urandom, $urandom});
         req_tuser  <= kind_type'($urandom);
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic length_type pick_length();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return length_type'($urandom_range(0, 127));
         4, 5, 6, 7: return length_type'($urandom_range(0, 16));
         8:          return length_type'(rbws_pkg::DEPTH);
         default:    return length_type'($urandom_range(rbws_pkg::DEPTH + 1, 127));
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_totals.size() == 0) begin
            log_failure("total with no query waiting", '0, rsp_tdata);
         end else begin
            oldest_total = expected_totals.pop_front();
            if (rsp_tdata !== oldest_total) begin
               log_failure("total mismatch", oldest_total, rsp_tdata);
            end
         end
      end
   end

   initial begin
      int rx_cycle;
      int mode;
      int phase_left;
      rsp_tready = 1'b0;
      rx_cycle   = 0;
      mode       = 0;
      phase_left = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (phase_left == 0) begin
            mode       = $urandom_range(0, 3);
            phase_left = $urandom_range(8, 80);
         end
         phase_left--;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_cycle % 7) < 3;
            endcase
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ring_buffer_window_sum: mismatch");
      $finish;
   end

   initial begin
      int       accepted;
      int       pick;
      kind_type kind;
      int       row;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      failures   = 0;
      burst_left = 0;
      shadow_head = 0;
      shadow_fill = 0;
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_COUNT; row++) begin
         drive_item(directed_rows[row].kind, directed_rows[row].sample,
                    directed_rows[row].len, directed_rows[row].typed_in,
                    directed_rows[row].total);
         pace_sender();
      end

      accepted = 0;
      while (accepted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 199);
         if (pick < 120)      kind = rbws_pkg::KIND_ADD;
         else if (pick < 184) kind = rbws_pkg::KIND_QUERY;
         else if (pick < 187) kind = rbws_pkg::KIND_CLEAR;
         else                 kind = KIND_UNUSED;
         drive_item(kind, pick_sample(), pick_length(), 1'b0, '0);
         accepted++;
         pace_sender();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("ring_buffer_window_sum: match");
      end else begin
         $display("ring_buffer_window_sum: mismatch");
      end
      $finish;
   end

endmodule
